// ----- rtl/bup_pkg.sv -----
// ----------------------------------------------------------------------------
// bup_pkg
// Shared constants, types and the reciprocal table of the bilinear upscaler.
// ----------------------------------------------------------------------------
package bup_pkg;

    localparam int IMG_WIDTH  = 256;
    localparam int IMG_HEIGHT = 256;

    // coordinate widths, at least two bits so that each bank keeps one
    localparam int COL_W = (IMG_WIDTH  > 4) ? $clog2(IMG_WIDTH)  : 2;
    localparam int ROW_W = (IMG_HEIGHT > 4) ? $clog2(IMG_HEIGHT) : 2;

    // four banks split by column and row parity
    localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int RECIP_SH = 20;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_QUERY = 1'b1;
    localparam logic [4:0] SCALE_RST  = 5'd4;
    localparam logic [4:0] SCALE_MAX  = 5'd16;

    // ceil(2^20 / s) for s = 1..16; exact quotient for values below 2^16
    localparam logic [20:0] RECIP [16] = '{
        21'd1048576, 21'd524288, 21'd349526, 21'd262144,
        21'd209716,  21'd174763, 21'd149797, 21'd131072,
        21'd116509,  21'd104858, 21'd95326,  21'd87382,
        21'd80660,   21'd74899,  21'd69906,  21'd65536
    };

    typedef struct packed {
        logic             func;
        logic             err;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [3:0]       fx;
        logic [3:0]       fy;
        logic [7:0]       pin;
        logic [4:0]       scale;
    } t_work;

    function automatic logic [20:0] f_recip(input logic [4:0] scale);
        logic [4:0] idx;
        idx = scale - 5'd1;
        return RECIP[idx[3:0]];
    endfunction

endpackage

// ----- rtl/bup_ram.sv -----
// ----------------------------------------------------------------------------
// bup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bup_front.sv -----
// ----------------------------------------------------------------------------
// bup_front
// Accepts items, splits query coordinates into source position and fraction,
// and flags coordinates outside the image.
// ----------------------------------------------------------------------------
module bup_front import bup_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [4:0]  i_scale,
    input  logic        i_func,
    input  logic [11:0] i_x_coord,
    input  logic [11:0] i_y_coord,
    input  logic [7:0]  i_pixel_in,
    output logic        o_push,
    output t_work       o_work
);

    // stage a: captured item
    logic        r_a_valid;
    logic        r_a_func;
    logic [11:0] r_a_x, r_a_y;
    logic [7:0]  r_a_pin;
    logic [4:0]  r_a_s;
    // stage b: quotients
    logic        r_b_valid;
    logic        r_b_func;
    logic [11:0] r_b_x, r_b_y, r_b_qx, r_b_qy;
    logic [7:0]  r_b_pin;
    logic [4:0]  r_b_s;
    // stage c: work entry
    logic        r_c_valid;
    t_work       r_c_work;

    logic [32:0] n_prod_x, n_prod_y;
    logic [16:0] n_back_x, n_back_y;
    logic [11:0] n_fx, n_fy;
    logic        n_err;
    t_work       n_work;

    always_comb begin
        n_prod_x = 33'(r_a_x) * 33'(f_recip(r_a_s));
        n_prod_y = 33'(r_a_y) * 33'(f_recip(r_a_s));
    end

    always_comb begin
        n_back_x = 17'(r_b_qx) * 17'(r_b_s);
        n_back_y = 17'(r_b_qy) * 17'(r_b_s);
        n_fx     = r_b_x - n_back_x[11:0];
        n_fy     = r_b_y - n_back_y[11:0];
        if (r_b_func == FUNC_QUERY) begin
            n_err = ({1'b0, r_b_qx} >= 13'(IMG_WIDTH)) || ({1'b0, r_b_qy} >= 13'(IMG_HEIGHT));
        end else begin
            n_err = ({1'b0, r_b_x} >= 13'(IMG_WIDTH)) || ({1'b0, r_b_y} >= 13'(IMG_HEIGHT));
        end
        n_work.func  = r_b_func;
        n_work.err   = n_err;
        n_work.col   = (r_b_func == FUNC_QUERY) ? r_b_qx[COL_W-1:0] : r_b_x[COL_W-1:0];
        n_work.row   = (r_b_func == FUNC_QUERY) ? r_b_qy[ROW_W-1:0] : r_b_y[ROW_W-1:0];
        n_work.fx    = n_fx[3:0];
        n_work.fy    = n_fy[3:0];
        n_work.pin   = r_b_pin;
        n_work.scale = r_b_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_a_func <= i_func;
        r_a_x    <= i_x_coord;
        r_a_y    <= i_y_coord;
        r_a_pin  <= i_pixel_in;
        r_a_s    <= i_scale;
        r_b_func <= r_a_func;
        r_b_x    <= r_a_x;
        r_b_y    <= r_a_y;
        r_b_pin  <= r_a_pin;
        r_b_s    <= r_a_s;
        r_b_qx   <= n_prod_x[RECIP_SH+11:RECIP_SH];
        r_b_qy   <= n_prod_y[RECIP_SH+11:RECIP_SH];
        r_c_work <= n_work;
    end

    assign o_push = r_c_valid;
    assign o_work = r_c_work;

endmodule

// ----- rtl/bup_queue.sv -----
// ----------------------------------------------------------------------------
// bup_queue
// Two-entry queue of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module bup_queue import bup_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_work o_work
);

    t_work       r_slot [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        n_do_push, n_do_pop;

    assign n_do_push = i_push && (r_count != 2'd2);
    assign n_do_pop  = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (n_do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (n_do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(n_do_push) - 2'(n_do_pop);
        end
        if (n_do_push) begin
            r_slot[r_wptr] <= i_work;
        end
    end

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_work  = r_slot[r_rptr];

endmodule

// ----- rtl/bup_back.sv -----
// ----------------------------------------------------------------------------
// bup_back
// Writes pixels into four parity banks, reads the four neighbours of a
// query, weights them and divides by the squared scale.
// ----------------------------------------------------------------------------
module bup_back import bup_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_work      i_work,
    output logic       o_done,
    output logic [7:0] o_pixel_out,
    output logic       o_error
);

    logic [COL_W:0]       n_col1;
    logic [ROW_W:0]       n_row1;
    logic [BANK_AW-1:0]   n_addr [4];
    logic [3:0]           n_we;
    logic [7:0]           w_rdata [4];
    logic [4:0]           n_ax, n_ay;
    logic [9:0]           n_w1, n_w2, n_w3, n_w4;

    // stage 1: bank access issued, weights
    logic       r1_valid, r1_query, r1_err;
    logic       r1_sx0, r1_sy0, r1_lastc, r1_lastr;
    logic [8:0] r1_w1, r1_w2, r1_w3, r1_w4;
    logic [4:0] r1_s;
    // stage 2: weighted sum
    logic        r2_valid, r2_query, r2_err;
    logic [15:0] r2_sum;
    logic [4:0]  r2_s;
    // stage 3: sum / s
    logic        r3_valid, r3_query, r3_err;
    logic [15:0] r3_t;
    logic [4:0]  r3_s;
    // output
    logic       r_done, r_error;
    logic [7:0] r_pixel;

    logic [7:0]  n_p1, n_p2, n_p3, n_p4;
    logic [17:0] n_sum;
    logic [36:0] n_q1, n_q2;

    always_comb begin
        n_col1 = {1'b0, i_work.col} + (COL_W+1)'(1);
        n_row1 = {1'b0, i_work.row} + (ROW_W+1)'(1);
        n_ax   = i_work.scale - {1'b0, i_work.fx};
        n_ay   = i_work.scale - {1'b0, i_work.fy};
        n_w1   = n_ax * n_ay;
        n_w2   = {1'b0, i_work.fx} * n_ay;
        n_w3   = n_ax * {1'b0, i_work.fy};
        n_w4   = {1'b0, i_work.fx} * {1'b0, i_work.fy};
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [COL_W-1:0] csel;
        logic [ROW_W-1:0] rsel;
        always_comb begin
            // the bank of matching parity takes the own column, the other the next one
            csel = (i_work.col[0] == b[0]) ? i_work.col : n_col1[COL_W-1:0];
            rsel = (i_work.row[0] == b[1]) ? i_work.row : n_row1[ROW_W-1:0];
            n_addr[b] = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
            n_we[b]   = i_valid && (i_work.func == FUNC_WRITE) && !i_work.err
                        && (i_work.col[0] == b[0]) && (i_work.row[0] == b[1]);
        end
        bup_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (n_we[b]),
            .i_waddr (n_addr[b]),
            .i_wdata (i_work.pin),
            .i_raddr (n_addr[b]),
            .o_rdata (w_rdata[b])
        );
    end

    always_comb begin
        n_p1 = w_rdata[{r1_sy0, r1_sx0}];
        n_p2 = w_rdata[{r1_sy0, ~r1_sx0}];
        n_p3 = w_rdata[{~r1_sy0, r1_sx0}];
        n_p4 = w_rdata[{~r1_sy0, ~r1_sx0}];
        if (r1_lastc) begin
            n_p2 = n_p1;
            n_p4 = n_p3;
        end
        if (r1_lastr) begin
            n_p3 = n_p1;
            n_p4 = n_p2;
        end
        n_sum = 18'(r1_w1 * n_p1) + 18'(r1_w2 * n_p2) + 18'(r1_w3 * n_p3) + 18'(r1_w4 * n_p4);
        n_q1  = 37'(r2_sum) * 37'(f_recip(r2_s));
        n_q2  = 37'(r3_t) * 37'(f_recip(r3_s));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_done   <= r3_valid;
        end
        r1_query <= (i_work.func == FUNC_QUERY);
        r1_err   <= i_work.err;
        r1_sx0   <= i_work.col[0];
        r1_sy0   <= i_work.row[0];
        r1_lastc <= (i_work.col == COL_W'(IMG_WIDTH - 1));
        r1_lastr <= (i_work.row == ROW_W'(IMG_HEIGHT - 1));
        r1_w1    <= n_w1[8:0];
        r1_w2    <= n_w2[8:0];
        r1_w3    <= n_w3[8:0];
        r1_w4    <= n_w4[8:0];
        r1_s     <= i_work.scale;
        r2_query <= r1_query;
        r2_err   <= r1_err;
        r2_sum   <= n_sum[15:0];
        r2_s     <= r1_s;
        r3_query <= r2_query;
        r3_err   <= r2_err;
        r3_t     <= n_q1[RECIP_SH+15:RECIP_SH];
        r3_s     <= r2_s;
        r_error  <= r3_err;
        r_pixel  <= (r3_query && !r3_err) ? n_q2[RECIP_SH+7:RECIP_SH] : 8'd0;
    end

    assign o_done      = r_done;
    assign o_pixel_out = r_pixel;
    assign o_error     = r_error;

endmodule

// ----- rtl/bilinear_upscale_pixel.sv -----
// ----------------------------------------------------------------------------
// bilinear_upscale_pixel
// Bilinear upscaler: pixel store plus interpolated pixel queries.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per item, in order,
// marked by o_done for one cycle; results cannot be held off. The front
// part divides coordinates by the scale with reciprocal multiplies over
// three stages; a two-entry queue feeds the back part, which reads the
// four neighbours at once from four parity banks and divides the weighted
// sum by scale squared in two more stages. The back part drains the queue
// every cycle, so busy stays low.
// Write the scale only while no item is in flight.
module bilinear_upscale_pixel import bup_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_func,
    input  logic [11:0] i_x_coord,
    input  logic [11:0] i_y_coord,
    input  logic [7:0]  i_pixel_in,
    output logic        o_done,
    output logic [7:0]  o_pixel_out,
    output logic        o_error
);

    logic [4:0] r_scale;
    logic [4:0] n_eff;
    logic       n_push, n_empty, n_full;
    t_work      n_fwork, n_qwork;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    // zero acts as one, above the limit clamps
    always_comb begin
        if (r_scale == 5'd0) begin
            n_eff = 5'd1;
        end else if (r_scale > SCALE_MAX) begin
            n_eff = SCALE_MAX;
        end else begin
            n_eff = r_scale;
        end
    end

    assign busy = n_full;

    bup_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (start && !busy),
        .i_scale    (n_eff),
        .i_func     (i_func),
        .i_x_coord  (i_x_coord),
        .i_y_coord  (i_y_coord),
        .i_pixel_in (i_pixel_in),
        .o_push     (n_push),
        .o_work     (n_fwork)
    );

    bup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_work  (n_fwork),
        .i_pop   (!n_empty),
        .o_empty (n_empty),
        .o_full  (n_full),
        .o_work  (n_qwork)
    );

    bup_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!n_empty),
        .i_work      (n_qwork),
        .o_done      (o_done),
        .o_pixel_out (o_pixel_out),
        .o_error     (o_error)
    );

endmodule
